/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFPT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("Same-cycle assertion failed.");

// Consequent must hold in the cycle after the antecedent.
`define LFPT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("Next-cycle assertion failed.");

`endif

/* hdl/lfpt_pkg.sv */
// ----------------------------------------------------------------------------
// Link fault pass-through package
// Table sizes, field widths, mode and state codes, and the control and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lfpt_pkg;

  // Table geometry.
  localparam int CARDS             = 4;
  localparam int SEGMENTS_PER_CARD = 4;
  localparam int TABLE_SIZE        = CARDS * SEGMENTS_PER_CARD;
  localparam int IDX_W             = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  // Field widths.
  localparam int MODE_W  = 2;
  localparam int STATE_W = 3;
  localparam int COUNT_W = 8;
  localparam int ENTRY_W = STATE_W + COUNT_W;

  // Stream payload widths.
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 16;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

  // Segment link fault propagation states.
  localparam logic [STATE_W-1:0] SEG_INIT    = 3'd0;
  localparam logic [STATE_W-1:0] SEG_BOTH_UP = 3'd1;
  localparam logic [STATE_W-1:0] SEG_A_FAIL  = 3'd2;
  localparam logic [STATE_W-1:0] SEG_B_FAIL  = 3'd3;
  localparam logic [STATE_W-1:0] SEG_RECOVER = 3'd4;

  // Reset value of the recheck limit.
  localparam logic [COUNT_W-1:0] MAX_CHECK_RESET = 8'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Latch the input item and read its table entry.
    logic execute;  // Update the entry and load the result register.
  } lfpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;  // Result register holds a transfer not yet taken.
  } lfpt_sts_t;

endpackage

/* hdl/link_fault_pass_through_fsm.sv */
// ----------------------------------------------------------------------------
// Link fault pass-through supervisor
// Per-segment link fault propagation for a table of port pairs.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_axis channel carries one item: a mode in
// tuser (check, start, stop) and in tdata the card and segment indexes and
// the two link statuses. Every item gives exactly one result transfer on
// m_axis with the port drive command (tuser set when it must be applied)
// and the segment's active bit, state and recheck counter.
// The accepting edge reads the segment's entry from the table RAM, and the
// first edge after it that finds the result register free applies the rules,
// writes the entry back and loads the result register. The input reopens
// after that edge, so the single table read port and the read-modify-write
// keep the block from taking an item before the last one is written back.
// s_axis_tready is high whenever no item is in progress, so the next item is
// taken while a finished result still waits. If m_axis stalls, the item in
// progress holds until the result register frees up.
// Reset clears the active bits, the result valid flag and the controller and
// loads the recheck limit with three; the state and counter of a segment
// are defined once it has been started. cfg_we_i writes the recheck limit.
// ----------------------------------------------------------------------------
module link_fault_pass_through_fsm import lfpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input item stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // card_index[1:0], segment_index[3:2],
                                               // link_up_a[4], link_up_b[5], zero[7:6]
  input  logic [MODE_W-1:0]    s_axis_tuser,   // mode[1:0]
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // drive_port_a[0], drive_port_b[1],
                                               // segment_active[2], fsm_state[5:3],
                                               // checks_left[13:6], zero[15:14]
  output logic                 m_axis_tuser,   // drive_update[0]
  // Recheck limit register.
  input  logic                 cfg_we_i,
  input  logic [COUNT_W-1:0]   cfg_wdata_i
);

  lfpt_cmd_t cmd;
  lfpt_sts_t sts;

  // Sequencer.
  lfpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, rules and result register.
  lfpt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (s_axis_tuser),
    .card_index_i    (s_axis_tdata[1:0]),
    .segment_index_i (s_axis_tdata[3:2]),
    .link_up_a_i     (s_axis_tdata[4]),
    .link_up_b_i     (s_axis_tdata[5]),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_o      (m_axis_tdata),
    .out_update_o    (m_axis_tuser)
  );

endmodule

/* hdl/lfpt_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lfpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/lfpt_ctrl.sv */
// ----------------------------------------------------------------------------
// Link fault pass-through controller
// Two-state sequencer: take an item and read its entry, then update the
// entry and load the result once the result register is free.
// ----------------------------------------------------------------------------
module lfpt_ctrl import lfpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lfpt_sts_t  sts_i,
  output lfpt_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q;
  logic state_d;

  // Commands and next state.
  always_comb begin
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    state_d       = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts_i.out_blocked) begin
          cmd_o.execute = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/lfpt_dp.sv */
// ----------------------------------------------------------------------------
// Link fault pass-through datapath
// Holds the item, the active bits, the state and counter table, the recheck
// limit and the result register, and applies the segment rules.
// ----------------------------------------------------------------------------
module lfpt_dp import lfpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfpt_cmd_t            cmd_i,
  output lfpt_sts_t            sts_o,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [1:0]           card_index_i,
  input  logic [1:0]           segment_index_i,
  input  logic                 link_up_a_i,
  input  logic                 link_up_b_i,
  input  logic                 cfg_we_i,
  input  logic [COUNT_W-1:0]   cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [M_TDATA_W-1:0] out_data_o,
  output logic                 out_update_o
);

  // Captured item.
  logic [MODE_W-1:0]  mode_q;
  logic [IDX_W-1:0]   idx_q;
  logic               a_q;
  logic               b_q;
  logic               inrange_q;
  logic [IDX_W-1:0]   idx_in;
  logic               inrange_in;

  // Table and limit.
  logic [TABLE_SIZE-1:0] active_q;
  logic [COUNT_W-1:0]    max_q;
  logic [ENTRY_W-1:0]    rdata;
  logic [STATE_W-1:0]    st_raw;
  logic [COUNT_W-1:0]    cnt_raw;

  // Rule results.
  logic               act_cur;
  logic               act_new;
  logic [STATE_W-1:0] st_new;
  logic [COUNT_W-1:0] cnt_new;
  logic               upd;
  logic               da;
  logic               db;
  logic               wr_en;

  // Result register.
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic                 out_update_q;

  // Table index and range check of the incoming item.
  assign inrange_in = (int'(card_index_i) < CARDS) && (int'(segment_index_i) < SEGMENTS_PER_CARD);
  assign idx_in     = IDX_W'(int'(card_index_i) * SEGMENTS_PER_CARD + int'(segment_index_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q    <= mode_i;
      idx_q     <= idx_in;
      a_q       <= link_up_a_i;
      b_q       <= link_up_b_i;
      inrange_q <= inrange_in;
    end
  end

  // State and counter table.
  lfpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_q),
    .wdata_i ({cnt_new, st_new}),
    .re_i    (cmd_i.capture),
    .raddr_i (idx_in),
    .rdata_o (rdata)
  );

  assign st_raw  = rdata[STATE_W-1:0];
  assign cnt_raw = rdata[ENTRY_W-1:STATE_W];
  assign act_cur = active_q[idx_q];

  // Segment rules.
  always_comb begin
    act_new = act_cur;
    st_new  = st_raw;
    cnt_new = cnt_raw;
    upd     = 1'b0;
    da      = 1'b0;
    db      = 1'b0;
    wr_en   = 1'b0;
    if (inrange_q) begin
      case (mode_q)
        MODE_START: begin
          if (!act_cur) begin
            act_new = 1'b1;
            st_new  = SEG_INIT;
            cnt_new = max_q;
            wr_en   = cmd_i.execute;
          end
        end
        MODE_STOP: begin
          if (act_cur) begin
            act_new = 1'b0;
            upd     = 1'b1;
            da      = 1'b1;
            db      = 1'b1;
          end
        end
        MODE_CHECK: begin
          if (act_cur) begin
            wr_en = cmd_i.execute;
            case (st_raw)
              SEG_A_FAIL: begin
                if (a_q) begin
                  st_new = SEG_RECOVER;
                  upd    = 1'b1;
                  da     = 1'b1;
                  db     = 1'b1;
                end
              end
              SEG_B_FAIL: begin
                if (b_q) begin
                  st_new = SEG_RECOVER;
                  upd    = 1'b1;
                  da     = 1'b1;
                  db     = 1'b1;
                end
              end
              SEG_RECOVER: begin
                if (a_q && b_q) begin
                  st_new  = SEG_BOTH_UP;
                  cnt_new = max_q;
                end else if (cnt_raw != '0) begin
                  cnt_new = cnt_raw - COUNT_W'(1);
                end else begin
                  st_new  = SEG_INIT;
                  cnt_new = max_q;
                end
              end
              // Initial, both up, and any out-of-range code act as initial
              // except that both up, with both links up, is left unchanged.
              default: begin
                if ((st_raw != SEG_BOTH_UP) && a_q && b_q) begin
                  st_new = SEG_BOTH_UP;
                end else if (!a_q && b_q) begin
                  st_new = SEG_A_FAIL;
                  upd    = 1'b1;
                  da     = 1'b1;
                end else if (a_q && !b_q) begin
                  st_new = SEG_B_FAIL;
                  upd    = 1'b1;
                  db     = 1'b1;
                end
              end
            endcase
          end
        end
        default: begin
          // Unused mode reports the status unchanged.
        end
      endcase
    end
  end

  // Active bits and recheck limit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      max_q    <= MAX_CHECK_RESET;
    end else begin
      if (cmd_i.execute && inrange_q) begin
        active_q[idx_q] <= act_new;
      end
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; an out-of-range item reports all zeros.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      if (inrange_q) begin
        out_data_q   <= M_TDATA_W'({cnt_new, st_new, act_new, db, da});
        out_update_q <= upd;
      end else begin
        out_data_q   <= '0;
        out_update_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_blocked = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign out_update_o      = out_update_q;

endmodule

/* hdl/lfpt_checker.sv */
// ----------------------------------------------------------------------------
// Link fault pass-through port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfpt_checker import lfpt_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  // A stalled result holds its valid and payload.
  `LFPT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // An accepted item keeps the input closed for the following cycle.
  `LFPT_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Without a drive update both drive values are low.
  `LFPT_ASSERT_IMP(a_no_drive, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[1:0] == 2'b00)

  // A drive update on an inactive segment comes from a stop and raises both ports.
  `LFPT_ASSERT_IMP(a_stop_drive, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser && !m_axis_tdata[2], m_axis_tdata[1:0] == 2'b11)

endmodule

bind link_fault_pass_through_fsm lfpt_checker u_lfpt_checker (.*);

/* verif/tb_link_fault_pass_through_fsm.sv */
// ----------------------------------------------------------------------------
// Testbench for the link fault pass-through supervisor
// Streams check, start, stop and unused-mode items into the segment table,
// predicts every result transfer with a local copy of the segment table, and
// compares each result field by field. Phases run under several recheck
// limits, with random idling on both streams except in the final phase.
// ----------------------------------------------------------------------------
module tb_link_fault_pass_through_fsm import lfpt_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  // Mode code that the block ignores.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int PHASES = 6;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [1:0]        card;
    logic [1:0]        seg;
    logic              link_a;
    logic              link_b;
  } link_item_t;

  typedef struct packed {
    logic               drive_update;
    logic               drive_a;
    logic               drive_b;
    logic               active;
    logic [STATE_W-1:0] state;
    logic [COUNT_W-1:0] checks_left;
  } seg_status_t;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0]    s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata = '0;

  // Segment table mirror and recheck limit.
  logic               seg_active [TABLE_SIZE] = '{default: 1'b0};
  logic [STATE_W-1:0] seg_fsm    [TABLE_SIZE] = '{default: '0};
  logic [COUNT_W-1:0] seg_checks [TABLE_SIZE] = '{default: '0};
  logic [COUNT_W-1:0] check_limit = MAX_CHECK_RESET;

  // Stimulus bookkeeping.
  link_item_t  pending_items[$];
  seg_status_t expected_status[$];
  link_item_t  cur_item;
  seg_status_t want_status;
  logic        ever_started [TABLE_SIZE] = '{default: 1'b0};
  bit          idling_on = 1'b1;
  int          send_gap = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          mode_count [4] = '{default: 0};
  int          drive_count = 0;
  int          fallback_count = 0;

  link_fault_pass_through_fsm DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Applies one link check to an active segment and returns the drive command.
  function automatic logic [2:0] run_link_check(int unsigned slot, logic a, logic b);
    logic [STATE_W-1:0] st;
    logic [2:0]         drive;
    drive = 3'b000;
    st = seg_fsm[slot];
    if (st > SEG_RECOVER) st = SEG_INIT;
    case (st)
      SEG_INIT, SEG_BOTH_UP: begin
        if (st == SEG_INIT && a && b) begin
          seg_fsm[slot] = SEG_BOTH_UP;
        end else if (!a && b) begin
          seg_fsm[slot] = SEG_A_FAIL;
          drive = 3'b110;
        end else if (a && !b) begin
          seg_fsm[slot] = SEG_B_FAIL;
          drive = 3'b101;
        end
      end
      SEG_A_FAIL: begin
        if (a) begin
          seg_fsm[slot] = SEG_RECOVER;
          drive = 3'b111;
        end
      end
      SEG_B_FAIL: begin
        if (b) begin
          seg_fsm[slot] = SEG_RECOVER;
          drive = 3'b111;
        end
      end
      default: begin
        if (a && b) begin
          seg_fsm[slot] = SEG_BOTH_UP;
          seg_checks[slot] = check_limit;
        end else if (seg_checks[slot] != '0) begin
          seg_checks[slot] = seg_checks[slot] - 1'b1;
        end else begin
          seg_fsm[slot] = SEG_INIT;
          seg_checks[slot] = check_limit;
          fallback_count++;
        end
      end
    endcase
    return drive;
  endfunction

  // Updates the table mirror for one item and returns the status it reports.
  function automatic seg_status_t apply_item(link_item_t it);
    seg_status_t r;
    int unsigned slot;
    logic [2:0]  drive;
    r = '0;
    drive = 3'b000;
    slot = it.card * SEGMENTS_PER_CARD + it.seg;
    mode_count[it.mode]++;
    case (it.mode)
      MODE_START: begin
        if (!seg_active[slot]) begin
          seg_active[slot] = 1'b1;
          seg_fsm[slot] = SEG_INIT;
          seg_checks[slot] = check_limit;
        end
      end
      MODE_STOP: begin
        if (seg_active[slot]) begin
          seg_active[slot] = 1'b0;
          drive = 3'b111;
        end
      end
      MODE_CHECK: begin
        if (seg_active[slot]) drive = run_link_check(slot, it.link_a, it.link_b);
      end
      default: ;
    endcase
    if (drive[2]) drive_count++;
    {r.drive_update, r.drive_a, r.drive_b} = drive;
    r.active = seg_active[slot];
    r.state = seg_fsm[slot];
    r.checks_left = seg_checks[slot];
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Input driver: presents queued items, with random gaps between transfers.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_status.push_back(apply_item(cur_item));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 5);
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, cur_item.link_b, cur_item.link_a, cur_item.seg,
                           cur_item.card};
          s_axis_tuser <= cur_item.mode;
        end
      end
    end
  end

  // Result monitor: checks each result transfer and stalls at random.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_status.size() == 0) begin
          $error("Result transfer arrived with no item outstanding");
          mismatch_count++;
        end else begin
          want_status = expected_status.pop_front();
          results_seen++;
          check_field("drive_update", 16'(want_status.drive_update), 16'(m_axis_tuser));
          check_field("drive_port_a", 16'(want_status.drive_a), 16'(m_axis_tdata[0]));
          check_field("drive_port_b", 16'(want_status.drive_b), 16'(m_axis_tdata[1]));
          check_field("segment_active", 16'(want_status.active), 16'(m_axis_tdata[2]));
          check_field("fsm_state", 16'(want_status.state), 16'(m_axis_tdata[5:3]));
          check_field("checks_left", 16'(want_status.checks_left),
                      16'(m_axis_tdata[13:6]));
          check_field("tdata padding", 16'd0, 16'(m_axis_tdata[15:14]));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transfer", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(logic [MODE_W-1:0] mode, int card, int seg, logic a, logic b);
    link_item_t it;
    it.mode = mode;
    it.card = 2'(card);
    it.seg = 2'(seg);
    it.link_a = a;
    it.link_b = b;
    if (mode == MODE_START) ever_started[card * SEGMENTS_PER_CARD + seg] = 1'b1;
    pending_items.push_back(it);
  endtask

  // Random items around a focus segment; a segment is always started first.
  task automatic add_random_items(int count);
    int unsigned focus;
    int unsigned slot;
    int unsigned pick;
    logic        a;
    logic        b;
    focus = $urandom_range(0, TABLE_SIZE - 1);
    repeat (count) begin
      if ($urandom_range(0, 15) == 0) focus = $urandom_range(0, TABLE_SIZE - 1);
      slot = ($urandom_range(0, 9) < 7) ? focus : $urandom_range(0, TABLE_SIZE - 1);
      // Both links down is favored so recovery counts down toward a fallback.
      if ($urandom_range(0, 2) == 0) begin
        a = 1'b0;
        b = 1'b0;
      end else begin
        a = 1'($urandom_range(0, 1));
        b = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      if (!ever_started[slot] || (pick >= 72 && pick < 82)) begin
        add_item(MODE_START, slot / SEGMENTS_PER_CARD, slot % SEGMENTS_PER_CARD, a, b);
      end else if (pick < 72) begin
        add_item(MODE_CHECK, slot / SEGMENTS_PER_CARD, slot % SEGMENTS_PER_CARD, a, b);
      end else if (pick < 92) begin
        add_item(MODE_STOP, slot / SEGMENTS_PER_CARD, slot % SEGMENTS_PER_CARD, a, b);
      end else begin
        add_item(MODE_UNUSED, slot / SEGMENTS_PER_CARD, slot % SEGMENTS_PER_CARD, a, b);
      end
    end
  endtask

  // Waits until every item was sent and every result has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_status.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [COUNT_W-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    check_limit = value;
    @(negedge clk_i);
  endtask

  initial begin
    logic [COUNT_W-1:0] phase_limit [PHASES];
    phase_limit = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd2, 8'd3};
    phase_limit[3] = COUNT_W'($urandom_range(4, 254));

    repeat (6) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Directed part under the reset limit of three.
    add_item(MODE_START, 0, 0, 1'b0, 1'b0);
    add_item(MODE_START, 3, 3, 1'b1, 1'b1);
    add_item(MODE_START, 3, 3, 1'b0, 1'b0);  // already active, ignored
    add_item(MODE_CHECK, 0, 0, 1'b1, 1'b1);  // initial to both up
    add_item(MODE_CHECK, 0, 0, 1'b0, 1'b1);  // first port fails, second forced down
    add_item(MODE_CHECK, 0, 0, 1'b0, 1'b0);
    add_item(MODE_CHECK, 0, 0, 1'b1, 1'b0);  // first port back, into recovery
    add_item(MODE_CHECK, 0, 0, 1'b0, 1'b1);  // one recheck spent
    add_item(MODE_CHECK, 0, 0, 1'b1, 1'b1);  // both up, counter reloaded
    add_item(MODE_CHECK, 0, 0, 1'b1, 1'b0);  // second port fails
    add_item(MODE_CHECK, 0, 0, 1'b1, 1'b0);
    add_item(MODE_CHECK, 0, 0, 1'b0, 1'b1);  // second port back, into recovery
    repeat (4) add_item(MODE_CHECK, 0, 0, 1'b0, 1'b0);  // count down, then fall back
    add_item(MODE_CHECK, 0, 0, 1'b0, 1'b0);
    add_item(MODE_UNUSED, 0, 0, 1'b1, 1'b1);
    add_item(MODE_STOP, 0, 0, 1'b0, 1'b0);   // active: both ports driven up
    add_item(MODE_STOP, 0, 0, 1'b1, 1'b1);   // already inactive
    add_item(MODE_CHECK, 0, 0, 1'b1, 1'b1);  // inactive segment, no change
    add_item(MODE_START, 0, 0, 1'b1, 1'b0);  // restart
    add_item(MODE_CHECK, 3, 3, 1'b0, 1'b0);
    add_item(MODE_STOP, 3, 3, 1'b1, 1'b1);
    wait_drained();

    // Random phases, each under its own recheck limit; the last one runs
    // both streams at full rate.
    for (int p = 0; p < PHASES; p++) begin
      write_limit(phase_limit[p]);
      if (p == PHASES - 1) idling_on = 1'b0;
      add_random_items(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    $display("Sent %0d checks, %0d starts, %0d stops and %0d unused-mode items",
             mode_count[MODE_CHECK], mode_count[MODE_START], mode_count[MODE_STOP],
             mode_count[MODE_UNUSED]);
    $display("Checked %0d results over %0d recheck limits: %0d drive commands, %0d fallbacks",
             results_seen, PHASES + 1, drive_count, fallback_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
